// ===== design/att_pkg.sv =====
// Shared types, constants and the keyword table for the assembly text tokenizer.
// No dependencies.
package att_pkg;

  localparam int KW_COUNT = 230;
  localparam int KW_KEY_W = 40;

  typedef enum logic [3:0] {
    TK_NUMBER   = 4'd0,
    TK_IDENT    = 4'd1,
    TK_KEYWORD  = 4'd2,
    TK_COMMA    = 4'd3,
    TK_LBRACKET = 4'd4,
    TK_RBRACKET = 4'd5,
    TK_LBRACE   = 4'd6,
    TK_RBRACE   = 4'd7,
    TK_PLUS     = 4'd8,
    TK_MINUS    = 4'd9,
    TK_ASTERISK = 4'd10,
    TK_DOLLAR   = 4'd11,
    TK_NEWLINE  = 4'd12,
    TK_END      = 4'd13,
    TK_ERROR    = 4'd14
  } token_kind_e;

  typedef enum logic [2:0] {
    SM_IDLE = 3'd0,
    SM_ZERO = 3'd1,
    SM_DEC  = 3'd2,
    SM_HEX  = 3'd3,
    SM_BIN  = 3'd4,
    SM_NAME = 3'd5
  } scan_mode_e;

  // One accepted character's worth of tokens: an optional flushed number or
  // name, then an optional single-character token.
  typedef struct packed {
    logic                has_a;
    logic                a_is_name;
    logic [63:0]         value;
    logic                sat;
    logic [63:0]         head;
    logic [7:0]          len;
    logic [KW_KEY_W-1:0] key;
    logic                has_b;
    token_kind_e         b_kind;
  } att_rec_t;

  // Names right-aligned, first character in the most significant used byte.
  localparam logic [KW_KEY_W-1:0] KW_TABLE [KW_COUNT] = '{
    "cr0","cr1","cr2","cr3","cr4","cr8",
    "dr0","dr1","dr2","dr3","dr4","dr5","dr6","dr7",
    "k1","k2","k3","k4","k5","k6","k7",
    "es","cs","ss","ds","fs","gs",
    "st0","st1","st2","st3","st4","st5","st6","st7",
    "bnd0","bnd1","bnd2","bnd3",
    "tmm0","tmm1","tmm2","tmm3","tmm4","tmm5","tmm6","tmm7",
    "mm0","mm1","mm2","mm3","mm4","mm5","mm6","mm7",
    "zmm0","zmm1","zmm2","zmm3","zmm4","zmm5","zmm6","zmm7",
    "zmm8","zmm9","zmm10","zmm11","zmm12","zmm13","zmm14","zmm15",
    "zmm16","zmm17","zmm18","zmm19","zmm20","zmm21","zmm22","zmm23",
    "zmm24","zmm25","zmm26","zmm27","zmm28","zmm29","zmm30","zmm31",
    "ymm0","ymm1","ymm2","ymm3","ymm4","ymm5","ymm6","ymm7",
    "ymm8","ymm9","ymm10","ymm11","ymm12","ymm13","ymm14","ymm15",
    "ymm16","ymm17","ymm18","ymm19","ymm20","ymm21","ymm22","ymm23",
    "ymm24","ymm25","ymm26","ymm27","ymm28","ymm29","ymm30","ymm31",
    "xmm0","xmm1","xmm2","xmm3","xmm4","xmm5","xmm6","xmm7",
    "xmm8","xmm9","xmm10","xmm11","xmm12","xmm13","xmm14","xmm15",
    "xmm16","xmm17","xmm18","xmm19","xmm20","xmm21","xmm22","xmm23",
    "xmm24","xmm25","xmm26","xmm27","xmm28","xmm29","xmm30","xmm31",
    "rax","rcx","rdx","rbx","rsp","rbp","rsi","rdi",
    "r8","r9","r10","r11","r12","r13","r14","r15",
    "eax","ecx","edx","ebx","esp","ebp","esi","edi",
    "r8d","r9d","r10d","r11d","r12d","r13d","r14d","r15d",
    "ax","cx","dx","bx","sp","bp","si","di",
    "r8w","r9w","r10w","r11w","r12w","r13w","r14w","r15w",
    "al","cl","dl","bl","spl","bpl","sil","dil",
    "ah","ch","dh","bh",
    "r8b","r9b","r10b","r11b","r12b","r13b","r14b","r15b",
    "byte","word","dword","qword","tword",
    "1to2","1to4","1to8","1to16","1to32",
    "rel"
  };

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

endpackage

// ===== design/att_front.sv =====
// Scanner front end: accepts characters, tracks the running token and builds
// one record of finished tokens per character. Depends on att_pkg.
module att_front import att_pkg::*; #(
  parameter int NameHeadChars = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  logic [7:0] char_code_i,
  input  logic     end_of_text_i,
  input  logic     force_keyword_i,
  output att_rec_t rec_o
);

  localparam int BufW = 8 * NameHeadChars;

  scan_mode_e          mode_q, mode_d;
  logic [63:0]         acc_q, acc_d;
  logic                clamp_q, clamp_d;
  logic                stop_q, stop_d;
  logic [BufW-1:0]     buf_q, buf_d;
  logic [7:0]          cnt_q, cnt_d;
  logic [KW_KEY_W-1:0] key_q, key_d;

  logic [7:0]  c;
  logic        hex_ok;
  logic [3:0]  hex_d;
  logic [67:0] sum10, sum16, sum2;

  assign c = char_code_i;

  always_comb begin
    hex_ok = 1'b1;
    hex_d  = 4'd0;
    if (is_dec(c)) begin
      hex_d = 4'(c - "0");
    end else if ((c >= "a") && (c <= "f")) begin
      hex_d = 4'(c - "a" + 8'd10);
    end else if ((c >= "A") && (c <= "F")) begin
      hex_d = 4'(c - "A" + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign sum10 = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + {64'd0, hex_d};
  assign sum16 = ({4'd0, acc_q} << 4) + {64'd0, hex_d};
  assign sum2  = ({4'd0, acc_q} << 1) + {64'd0, hex_d};

  always_comb begin
    logic redispatch;
    logic [67:0] sum;
    logic do_acc;
    redispatch = 1'b0;
    do_acc     = 1'b0;
    sum        = sum10;
    mode_d  = mode_q;
    acc_d   = acc_q;
    clamp_d = clamp_q;
    stop_d  = stop_q;
    buf_d   = buf_q;
    cnt_d   = cnt_q;
    key_d   = key_q;
    rec_o   = '0;
    rec_o.b_kind = TK_END;

    if (end_of_text_i) begin
      if (mode_q != SM_IDLE) begin
        rec_o.has_a = 1'b1;
      end
      rec_o.has_b  = 1'b1;
      rec_o.b_kind = TK_END;
      mode_d  = SM_IDLE;
      acc_d   = '0;
      clamp_d = 1'b0;
      stop_d  = 1'b0;
      buf_d   = '0;
      cnt_d   = '0;
      key_d   = '0;
    end else begin
      case (mode_q)
        SM_ZERO: begin
          if (c == "x") begin
            mode_d = SM_HEX;
          end else if (c == "b") begin
            mode_d = SM_BIN;
          end else if (is_dec(c)) begin
            mode_d = SM_DEC;
            acc_d  = {60'd0, hex_d};
          end else begin
            rec_o.has_a = 1'b1;
            redispatch  = 1'b1;
          end
        end
        SM_DEC: begin
          if (is_dec(c)) begin
            do_acc = 1'b1;
            sum    = sum10;
          end else begin
            rec_o.has_a = 1'b1;
            redispatch  = 1'b1;
          end
        end
        SM_HEX: begin
          if (hex_ok) begin
            do_acc = 1'b1;
            sum    = sum16;
          end else begin
            rec_o.has_a = 1'b1;
            redispatch  = 1'b1;
          end
        end
        SM_BIN: begin
          if (hex_ok) begin
            if (!stop_q && (hex_d < 4'd2)) begin
              do_acc = 1'b1;
              sum    = sum2;
            end else begin
              stop_d = 1'b1;
            end
          end else begin
            rec_o.has_a = 1'b1;
            redispatch  = 1'b1;
          end
        end
        SM_NAME: begin
          if (is_letter(c) || is_dec(c)) begin
            for (int i = 0; i < NameHeadChars; i++) begin
              if (cnt_q == 8'(i)) begin
                buf_d[8*i +: 8] = c;
              end
            end
            if (cnt_q != 8'hFF) begin
              cnt_d = cnt_q + 8'd1;
            end
            key_d = {key_q[KW_KEY_W-9:0], c};
          end else begin
            rec_o.has_a = 1'b1;
            redispatch  = 1'b1;
          end
        end
        default: begin
          redispatch = 1'b1;
        end
      endcase

      // Saturate: once clamped, drop further digits.
      if (do_acc && !clamp_q) begin
        if (sum[67:64] != 4'd0) begin
          acc_d   = '1;
          clamp_d = 1'b1;
        end else begin
          acc_d = sum[63:0];
        end
      end

      if (redispatch) begin
        mode_d  = SM_IDLE;
        acc_d   = '0;
        clamp_d = 1'b0;
        stop_d  = 1'b0;
        buf_d   = '0;
        cnt_d   = '0;
        key_d   = '0;
        if ((c == " ") || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0B) ||
            (c == 8'h0C)) begin
          mode_d = SM_IDLE;
        end else if (is_dec(c) && !force_keyword_i) begin
          if (c == "0") begin
            mode_d = SM_ZERO;
          end else begin
            mode_d = SM_DEC;
            acc_d  = {60'd0, hex_d};
          end
        end else if (is_letter(c) || is_dec(c)) begin
          mode_d         = SM_NAME;
          buf_d[7:0]     = c;
          cnt_d          = 8'd1;
          key_d          = {{(KW_KEY_W-8){1'b0}}, c};
        end else begin
          rec_o.has_b = 1'b1;
          case (c)
            ",":     rec_o.b_kind = TK_COMMA;
            "[":     rec_o.b_kind = TK_LBRACKET;
            "]":     rec_o.b_kind = TK_RBRACKET;
            "{":     rec_o.b_kind = TK_LBRACE;
            "}":     rec_o.b_kind = TK_RBRACE;
            "+":     rec_o.b_kind = TK_PLUS;
            "-":     rec_o.b_kind = TK_MINUS;
            "*":     rec_o.b_kind = TK_ASTERISK;
            "$":     rec_o.b_kind = TK_DOLLAR;
            8'h0A:   rec_o.b_kind = TK_NEWLINE;
            default: rec_o.b_kind = TK_ERROR;
          endcase
        end
      end
    end

    // Flushed token is taken from the state before this character.
    if (rec_o.has_a) begin
      rec_o.a_is_name = (mode_q == SM_NAME);
      if (mode_q == SM_NAME) begin
        rec_o.head = 64'(buf_q);
        rec_o.len  = cnt_q;
        rec_o.key  = key_q;
      end else begin
        rec_o.value = acc_q;
        rec_o.sat   = clamp_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= SM_IDLE;
      acc_q   <= '0;
      clamp_q <= 1'b0;
      stop_q  <= 1'b0;
      buf_q   <= '0;
      cnt_q   <= '0;
      key_q   <= '0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      acc_q   <= acc_d;
      clamp_q <= clamp_d;
      stop_q  <= stop_d;
      buf_q   <= buf_d;
      cnt_q   <= cnt_d;
      key_q   <= key_d;
    end
  end

endmodule

// ===== design/att_fifo.sv =====
// Two-entry record queue between scanner and emitter.
// Depends on att_pkg.
module att_fifo import att_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  att_rec_t wdata_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output att_rec_t rdata_o
);

  att_rec_t    mem_q [2];
  logic        wptr_q, rptr_q;
  logic [1:0]  cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// ===== design/att_back.sv =====
// Emitter: matches names against the keyword table and streams the tokens of
// each queued record through an output register. Depends on att_pkg.
module att_back import att_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  att_rec_t    head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output token_kind_e kind_o,
  output logic [7:0]  kw_index_o,
  output logic [63:0] value_o,
  output logic        sat_o,
  output logic [63:0] head_o,
  output logic [7:0]  len_o,
  output logic        last_o
);

  logic        phase_q;
  logic        valid_q;
  logic        load;
  logic        on_a;
  logic        is_last;
  logic        hit;
  logic [7:0]  hit_idx;

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (head_i.key == KW_TABLE[k]) begin
        hit     = 1'b1;
        hit_idx = 8'(k);
      end
    end
    if ((head_i.len == 8'd0) || (head_i.len > 8'd5)) begin
      hit = 1'b0;
    end
  end

  assign on_a    = !phase_q && head_i.has_a;
  assign is_last = on_a ? !head_i.has_b : 1'b1;
  assign load    = head_valid_i && (!valid_q || out_ready_i);
  assign pop_o   = load && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        phase_q <= !is_last;
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_o     <= head_i.b_kind;
      kw_index_o <= '0;
      value_o    <= '0;
      sat_o      <= 1'b0;
      head_o     <= '0;
      len_o      <= '0;
      last_o     <= is_last;
      if (on_a) begin
        if (head_i.a_is_name) begin
          kind_o     <= hit ? TK_KEYWORD : TK_IDENT;
          kw_index_o <= hit ? hit_idx : 8'd0;
          head_o     <= head_i.head;
          len_o      <= head_i.len;
        end else begin
          kind_o  <= TK_NUMBER;
          value_o <= head_i.value;
          sat_o   <= head_i.sat;
        end
      end
    end
  end

  assign out_valid_o = valid_q;

  a_phase_needs_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (head_valid_i && head_i.has_a && head_i.has_b))
    else $error("second token pending without a two-token record");

  a_record_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> (head_i.has_a || head_i.has_b))
    else $error("queued record carries no token");

  a_pop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (valid_q && last_o && !phase_q))
    else $error("record popped before its final token");

endmodule

// ===== design/assembly_text_tokenizer_unit.sv =====
// Assembly text tokenizer top level: scanner, record queue and emitter.
// Depends on att_pkg, att_front, att_fifo, att_back.
//
// Takes one text character per cycle and, while out_ready_i is high, emits
// tokens one per cycle through a registered output. A character that both
// ends a number or name and is itself a token (or an end-of-text mark with a
// pending token) yields two tokens, emitted in turn; a two-entry queue between
// the scanner and the emitter absorbs this, and input is held off only while
// that queue is full. An accepted character's record is written into the queue
// and then loaded into the output register. The keyword lookup compares the
// name against all table entries in parallel in the emitter stage.
module assembly_text_tokenizer_unit import att_pkg::*; #(
  parameter int NAME_HEAD_CHARS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic        end_of_text_i,
  input  logic        force_keyword_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  token_kind_o,
  output logic [7:0]  keyword_index_o,
  output logic [63:0] number_value_o,
  output logic        number_saturated_o,
  output logic [63:0] name_head_o,
  output logic [7:0]  name_length_o,
  output logic        last_o
);

  att_rec_t    rec, head;
  logic        accept, full, head_valid, pop;
  token_kind_e kind;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && !full;

  att_front #(.NameHeadChars(NAME_HEAD_CHARS)) u_front (
    .clk_i, .rst_ni,
    .accept_i        (accept),
    .char_code_i,
    .end_of_text_i,
    .force_keyword_i,
    .rec_o           (rec)
  );

  att_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i  (accept && (rec.has_a || rec.has_b)),
    .wdata_i (rec),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .rdata_o (head)
  );

  att_back u_back (
    .clk_i, .rst_ni,
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o,
    .out_ready_i,
    .kind_o       (kind),
    .kw_index_o   (keyword_index_o),
    .value_o      (number_value_o),
    .sat_o        (number_saturated_o),
    .head_o       (name_head_o),
    .len_o        (name_length_o),
    .last_o
  );

  assign token_kind_o = kind;

endmodule

// ===== sim/tb_assembly_text_tokenizer_unit.sv =====
// Self-checking testbench for assembly_text_tokenizer_unit: streams text
// characters, predicts every token and compares each one field by field.
// Depends on att_pkg and the tokenizer RTL.
`timescale 1ns / 100ps

module tb_assembly_text_tokenizer_unit;
  import att_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int PHASE_LEN    = 620;

  typedef struct {
    logic [7:0] c;
    logic       eot;
    logic       fk;
    logic       drain;
  } char_item_t;

  typedef struct {
    logic [3:0]  kind;
    logic [7:0]  kwi;
    logic [63:0] val;
    logic        sat;
    logic [63:0] head;
    logic [7:0]  len;
    logic        last;
  } token_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  char_code_i;
  logic        end_of_text_i;
  logic        force_keyword_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [3:0]  token_kind_o;
  logic [7:0]  keyword_index_o;
  logic [63:0] number_value_o;
  logic        number_saturated_o;
  logic [63:0] name_head_o;
  logic [7:0]  name_length_o;
  logic        last_o;

  char_item_t text_q[$];
  token_t     token_expect_q[$];
  token_t     new_tokens[$];

  // predictor state
  scan_mode_e  lex_mode;
  logic [63:0] lex_value;
  logic        lex_clamped;
  logic        lex_bin_stop;
  logic [63:0] lex_name;
  logic [7:0]  lex_count;

  int n_accepted = 0;
  int n_tokens = 0;
  int n_errors = 0;
  int n_keywords = 0;
  int n_sat = 0;
  int cycles = 0;
  int stall_left = 0;
  bit stall_done = 0;

  always #5 clk_i = ~clk_i;

  assembly_text_tokenizer_unit dut (.*);

  // ---------------- predictor ----------------
  function automatic int hex_val(logic [7:0] c);
    if (is_dec(c)) return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0B || c == 8'h0C;
  endfunction

  task automatic accumulate(int base, int d);
    if (lex_clamped) return;
    if (lex_value > (64'hFFFF_FFFF_FFFF_FFFF - 64'(d)) / 64'(base)) begin
      lex_value   = '1;
      lex_clamped = 1'b1;
    end else begin
      lex_value = lex_value * 64'(base) + 64'(d);
    end
  endtask

  task automatic push_kind(token_kind_e k);
    token_t t;
    t = '{kind: k, default: '0};
    new_tokens.push_back(t);
  endtask

  task automatic push_number();
    token_t t;
    t = '{kind: TK_NUMBER, default: '0};
    t.val = lex_value;
    t.sat = lex_clamped;
    new_tokens.push_back(t);
  endtask

  task automatic push_name();
    token_t t;
    logic [KW_KEY_W-1:0] key;
    t = '{kind: TK_IDENT, default: '0};
    t.head = lex_name;
    t.len  = lex_count;
    // only short names can be table entries; build the key first char high
    if (lex_count < 6) begin
      key = '0;
      for (int i = 0; i < lex_count; i++) key = (key << 8) | lex_name[8*i +: 8];
      for (int k = 0; k < KW_COUNT; k++) begin
        if (KW_TABLE[k] == key) begin
          t.kind = TK_KEYWORD;
          t.kwi  = 8'(k);
          break;
        end
      end
    end
    new_tokens.push_back(t);
  endtask

  task automatic name_append(logic [7:0] c);
    if (lex_count < 8) lex_name |= 64'(c) << (8 * lex_count);
    if (lex_count < 255) lex_count++;
  endtask

  task automatic clear_token();
    lex_value = '0; lex_clamped = 0; lex_bin_stop = 0; lex_name = '0; lex_count = '0;
  endtask

  task automatic start_token(logic [7:0] c, logic fk);
    clear_token();
    lex_mode = SM_IDLE;
    if (is_blank(c)) return;
    if (is_dec(c) && !fk) begin
      if (c == "0") lex_mode = SM_ZERO;
      else begin
        lex_mode  = SM_DEC;
        lex_value = 64'(c - "0");
      end
      return;
    end
    if (is_letter(c) || (fk && is_dec(c))) begin
      lex_mode = SM_NAME;
      name_append(c);
      return;
    end
    case (c)
      ",":     push_kind(TK_COMMA);
      "[":     push_kind(TK_LBRACKET);
      "]":     push_kind(TK_RBRACKET);
      "{":     push_kind(TK_LBRACE);
      "}":     push_kind(TK_RBRACE);
      "+":     push_kind(TK_PLUS);
      "-":     push_kind(TK_MINUS);
      "*":     push_kind(TK_ASTERISK);
      "$":     push_kind(TK_DOLLAR);
      8'h0A:   push_kind(TK_NEWLINE);
      default: push_kind(TK_ERROR);
    endcase
  endtask

  task automatic scan_char(logic [7:0] c, logic eot, logic fk);
    int d;
    new_tokens.delete();
    if (eot) begin
      if (lex_mode == SM_NAME) push_name();
      else if (lex_mode != SM_IDLE) push_number();
      push_kind(TK_END);
      lex_mode = SM_IDLE;
      clear_token();
    end else begin
      d = hex_val(c);
      case (lex_mode)
        SM_ZERO: begin
          if (c == "x") lex_mode = SM_HEX;
          else if (c == "b") lex_mode = SM_BIN;
          else if (is_dec(c)) begin
            lex_mode  = SM_DEC;
            lex_value = 64'(c - "0");
          end else begin
            push_number();
            start_token(c, fk);
          end
        end
        SM_DEC: begin
          if (is_dec(c)) accumulate(10, c - "0");
          else begin
            push_number();
            start_token(c, fk);
          end
        end
        SM_HEX: begin
          if (d >= 0) accumulate(16, d);
          else begin
            push_number();
            start_token(c, fk);
          end
        end
        SM_BIN: begin
          if (d >= 0) begin
            // keep only the leading run of binary digits
            if (!lex_bin_stop && d < 2) accumulate(2, d);
            else lex_bin_stop = 1'b1;
          end else begin
            push_number();
            start_token(c, fk);
          end
        end
        SM_NAME: begin
          if (is_letter(c) || is_dec(c)) name_append(c);
          else begin
            push_name();
            start_token(c, fk);
          end
        end
        default: start_token(c, fk);
      endcase
    end
    if (new_tokens.size() > 0) new_tokens[new_tokens.size() - 1].last = 1'b1;
    foreach (new_tokens[i]) token_expect_q.push_back(new_tokens[i]);
  endtask

  // ---------------- driver ----------------
  function automatic int phase();
    return (n_accepted < PHASE_LEN) ? 0 : (n_accepted < 2 * PHASE_LEN) ? 1 : 2;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    char_item_t it;
    int gap_pct;
    if (!rst_ni) begin
      in_valid_i      <= 1'b0;
      char_code_i     <= '0;
      end_of_text_i   <= 1'b0;
      force_keyword_i <= 1'b0;
      lex_mode = SM_IDLE;
      clear_token();
    end else begin
      if (in_valid_i && in_ready_o) begin
        scan_char(char_code_i, end_of_text_i, force_keyword_i);
        n_accepted++;
      end
      if (!in_valid_i || in_ready_o) begin
        gap_pct = (phase() == 0) ? 15 : (phase() == 1) ? 56 : 0;
        // hold the drain-marked transaction until every token is back
        if (text_q.size() > 0 && !(text_q[0].drain && token_expect_q.size() > 0)
            && $urandom_range(0, 99) >= gap_pct) begin
          it = text_q.pop_front();
          in_valid_i      <= 1'b1;
          char_code_i     <= it.c;
          end_of_text_i   <= it.eot;
          force_keyword_i <= it.fk;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk_i or negedge rst_ni) begin
    token_t t;
    int stall_pct;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        n_tokens++;
        if (token_expect_q.size() == 0) begin
          $error("unexpected token kind %0d", token_kind_o);
          n_errors++;
        end else begin
          t = token_expect_q.pop_front();
          if (t.kind == TK_KEYWORD) n_keywords++;
          if (t.sat) n_sat++;
          if (token_kind_o !== t.kind) begin
            $error("token_kind exp %0d got %0d", t.kind, token_kind_o); n_errors++;
          end
          if (keyword_index_o !== t.kwi) begin
            $error("keyword_index exp %0d got %0d", t.kwi, keyword_index_o); n_errors++;
          end
          if (number_value_o !== t.val) begin
            $error("number_value exp %h got %h", t.val, number_value_o); n_errors++;
          end
          if (number_saturated_o !== t.sat) begin
            $error("number_saturated exp %b got %b", t.sat, number_saturated_o);
            n_errors++;
          end
          if (name_head_o !== t.head) begin
            $error("name_head exp %h got %h", t.head, name_head_o); n_errors++;
          end
          if (name_length_o !== t.len) begin
            $error("name_length exp %0d got %0d", t.len, name_length_o); n_errors++;
          end
          if (last_o !== t.last) begin
            $error("last exp %b got %b", t.last, last_o); n_errors++;
          end
        end
      end
      // one long hold-off so the internal queue fills and input stalls
      if (!stall_done && n_accepted >= 150) begin
        stall_done = 1;
        stall_left = 400;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        stall_pct = (phase() == 0) ? 56 : (phase() == 1) ? 15 : 0;
        out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb_assembly_text_tokenizer_unit: FAIL");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  task automatic put(logic [7:0] c, logic fk = 0, logic eot = 0);
    char_item_t it;
    it = '{c: c, eot: eot, fk: fk, drain: 0};
    // drain before each idling phase change
    if (text_q.size() == PHASE_LEN || text_q.size() == 2 * PHASE_LEN) it.drain = 1;
    text_q.push_back(it);
  endtask

  task automatic put_str(string s);
    for (int i = 0; i < s.len(); i++) put(s[i], ($urandom_range(0, 15) == 0));
  endtask

  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  task automatic put_word();
    logic [KW_KEY_W-1:0] kw;
    int n;
    case ($urandom_range(0, 12))
      0, 1: begin
        kw = KW_TABLE[$urandom_range(0, KW_COUNT - 1)];
        for (int i = 4; i >= 0; i--) if (kw[8*i +: 8] != 0) put(kw[8*i +: 8]);
      end
      2: begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 8);
        put(pick("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ"));
        repeat (n - 1) put(pick("abcdekmrswxyz0123456789QRZ"));
      end
      3: begin
        n = $urandom_range(1, 24);
        put(pick("123456789"));
        repeat (n - 1) put(pick("0123456789"));
      end
      4: begin
        put("0"); put("x");
        repeat ($urandom_range(0, 19)) put(pick("0123456789abcdefABCDEF"));
      end
      5: begin
        put("0"); put("b");
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 12);
        repeat (n) put(($urandom_range(0, 19) == 0) ? pick("23456789aF") : pick("01"));
      end
      6, 7: put(pick(",[]{}+-*$"));
      8: put(8'h0A);
      9: put(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      10: begin
        put(pick("0123456789"), 1'b1);
        repeat ($urandom_range(0, 5)) put(pick("to0123456789"));
      end
      11: put(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
      default: begin
        put("0");
        if ($urandom_range(0, 1)) put(pick("0123456789"));
      end
    endcase
    if ($urandom_range(0, 1)) put(pick(" \t\r"));
  endtask

  initial begin
    // directed: prefixes without digits, binary cut short, leading zeros,
    // punctuation, an unknown byte, end flush and a forced digit-led name
    put_str("0x,0b0121 07 0");
    put(8'h01);
    put("9"); put(8'hFF, 1'b0, 1'b1);
    put("1", 1'b1); put("t"); put("o"); put("8"); put(8'h00, 1'b1, 1'b1);
    put("}"); put(8'h0B); put(8'h0C);
    // one name longer than the length counter can hold
    put("q");
    repeat (300) put(pick("az09"));
    put(8'h0A);
    while (text_q.size() < 1850) put_word();
    put(8'h00, 1'b0, 1'b1);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sample away from the active edge so driver updates have settled
    do @(negedge clk_i);
    while (text_q.size() != 0 || in_valid_i || token_expect_q.size() != 0);
    repeat (20) @(posedge clk_i);

    $display("covered %0d characters, %0d tokens (%0d keywords, %0d saturated numbers)",
             n_accepted, n_tokens, n_keywords, n_sat);
    if (n_errors == 0 && token_expect_q.size() == 0) begin
      $display("tb_assembly_text_tokenizer_unit: PASS");
    end else begin
      $display("tb_assembly_text_tokenizer_unit: FAIL");
    end
    $finish;
  end

endmodule
